// ===== rtl/mfs_pkg.sv =====
// shared constants for the mobius function sieve
// no dependencies
package mfs_pkg;
    localparam int unsigned MAX_N_DEF   = 65535;
    localparam int unsigned IDX_W       = 16;
    localparam int unsigned MU_W        = 2;
    localparam int unsigned STATUS_W    = 2;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_UNBUILT   = 2'd2;
    localparam logic       OP_BUILD     = 1'b0;
    localparam logic       OP_QUERY     = 1'b1;
    localparam logic [1:0] MU_ZERO      = 2'b00;
    localparam logic [1:0] MU_ONE       = 2'b01;
    localparam logic [1:0] MU_NEG       = 2'b11;
endpackage

// ===== rtl/mfs_div.sv =====
// restoring divider, one quotient bit per cycle; quotient and remainder
// depends on mfs_pkg
module mfs_div #(
    parameter int unsigned W = mfs_pkg::IDX_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int unsigned CW = $clog2(W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_r;
    logic [W-1:0]  r_d;
    logic          r_done;
    logic [W:0]    w_sh;
    logic [W:0]    w_sub;

    assign w_sh  = {r_r, r_q[W-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_q    <= i_num;
                r_r    <= '0;
                r_d    <= i_den;
            end else if (r_busy) begin
                if (w_sub[W]) begin
                    r_r <= w_sh[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b0};
                end else begin
                    r_r <= w_sub[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;
endmodule

// ===== rtl/mobius_function_sieve_top.sv =====
// Mobius function sieve: a build fills factor and mu memories for 0..limit
// (limit clamped to MAX_N): it inits every factor entry, sieves each root
// tried and marks its multiples, then derives mu per entry, with a division
// by the bit-serial divider for each composite one; a query result is
// registered through S_Q_RD and S_Q_OUT. One word at a time.
// depends on mfs_pkg and mfs_div
module mobius_function_sieve_top #(
    parameter int unsigned MAX_N = mfs_pkg::MAX_N_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [15:0] i_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [1:0] o_mobius_value,
    output logic [15:0] o_smallest_factor,
    output logic        o_prime_flag,
    output logic [1:0]  o_status
);
    localparam int unsigned AW = (MAX_N > 65535) ? $clog2(MAX_N + 1) : 16;
    localparam int unsigned DW = AW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_OUT_RD, S_OUT_WT, S_OUT_CHK, S_IN_RD, S_IN_WR,
        S_MU_RD, S_MU_WT, S_MU_DIV, S_MU_RDM, S_MU_WR, S_Q_RD, S_Q_OUT, S_RESP
    } t_state;

    t_state         r_state;
    logic [15:0]    r_limit;
    logic           r_built;
    logic [AW-1:0]  r_lim;
    logic [AW-1:0]  r_outer;
    logic [DW-1:0]  r_inner;
    logic [AW-1:0]  r_n;
    logic [AW-1:0]  r_p;
    logic [AW-1:0]  r_m;
    logic [15:0]    r_idx;
    logic [AW-1:0]  r_fac_mem [0:MAX_N];
    logic [1:0]     r_mu_mem  [0:MAX_N];
    logic [AW-1:0]  r_fac_rd;
    logic [1:0]     r_mu_rd;
    logic           r_fac_we;
    logic [AW-1:0]  r_fac_wa;
    logic [AW-1:0]  r_fac_wd;
    logic           r_mu_we;
    logic [AW-1:0]  r_mu_wa;
    logic [1:0]     r_mu_wd;
    logic [AW-1:0]  r_ra;
    logic           r_ovalid;
    logic [1:0]     r_omu;
    logic [15:0]    r_ofac;
    logic           r_oprime;
    logic [1:0]     r_ostat;
    logic           r_div_go;
    logic           w_div_done;
    logic [AW-1:0]  w_quo;
    logic [AW-1:0]  w_rem;
    logic [2*AW-1:0] w_sq;
    logic [AW-1:0]  w_elim;

    assign w_elim = (AW'(r_limit) > AW'(MAX_N)) ? AW'(MAX_N) : AW'(r_limit);
    assign w_sq   = r_outer * r_outer;

    mfs_div #(.W(AW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_n), .i_den(r_p), .o_done(w_div_done), .o_quo(w_quo), .o_rem(w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (r_fac_we) r_fac_mem[r_fac_wa] <= r_fac_wd;
        r_fac_rd <= r_fac_mem[r_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_mu_we) r_mu_mem[r_mu_wa] <= r_mu_wd;
        r_mu_rd <= r_mu_mem[r_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= 16'hFFFF;
            r_built  <= 1'b0;
            r_ovalid <= 1'b0;
            r_fac_we <= 1'b0;
            r_mu_we  <= 1'b0;
            r_div_go <= 1'b0;
            r_outer  <= '0;
            r_inner  <= '0;
        end else begin
            r_fac_we <= 1'b0;
            r_mu_we  <= 1'b0;
            r_div_go <= 1'b0;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
                r_built <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_idx <= i_index;
                        r_lim <= w_elim;
                        if (i_operation == mfs_pkg::OP_BUILD) begin
                            r_n     <= '0;
                            r_state <= S_INIT;
                        end else begin
                            r_ra    <= AW'(i_index);
                            r_state <= S_Q_RD;
                        end
                    end
                end
                S_INIT: begin
                    r_fac_we <= 1'b1;
                    r_fac_wa <= r_n;
                    r_fac_wd <= r_n;
                    if (r_n == r_lim) begin
                        r_outer <= AW'(2);
                        r_state <= S_OUT_RD;
                    end else begin
                        r_n <= r_n + 1'b1;
                    end
                end
                S_OUT_RD: begin
                    if (w_sq > (2*AW)'(r_lim)) begin
                        r_outer <= '0;
                        r_inner <= '0;
                        r_mu_we <= 1'b1;
                        r_mu_wa <= '0;
                        r_mu_wd <= mfs_pkg::MU_ZERO;
                        r_n     <= AW'(1);
                        r_state <= S_MU_RD;
                    end else begin
                        r_ra    <= r_outer;
                        r_inner <= DW'(w_sq);
                        r_state <= S_OUT_WT;
                    end
                end
                S_OUT_WT: r_state <= S_OUT_CHK;
                S_OUT_CHK: begin
                    if (r_fac_rd == r_outer) begin
                        r_ra    <= r_inner[AW-1:0];
                        r_state <= S_IN_RD;
                    end else begin
                        r_outer <= r_outer + 1'b1;
                        r_state <= S_OUT_RD;
                    end
                end
                S_IN_RD: r_state <= S_IN_WR;
                S_IN_WR: begin
                    if (r_fac_rd == r_inner[AW-1:0]) begin
                        r_fac_we <= 1'b1;
                        r_fac_wa <= r_inner[AW-1:0];
                        r_fac_wd <= r_outer;
                    end
                    if (r_inner + DW'(r_outer) > DW'(r_lim)) begin
                        r_inner <= '0;
                        r_outer <= r_outer + 1'b1;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_inner <= r_inner + DW'(r_outer);
                        r_ra    <= r_inner[AW-1:0] + r_outer;
                        r_state <= S_IN_RD;
                    end
                end
                S_MU_RD: begin
                    if ((r_n > r_lim) || (r_n == '0)) begin
                        r_built  <= 1'b1;
                        r_omu    <= mfs_pkg::MU_ZERO;
                        r_ofac   <= '0;
                        r_oprime <= 1'b0;
                        r_ostat  <= mfs_pkg::ST_OK;
                        r_ovalid <= 1'b1;
                        r_state  <= S_RESP;
                    end else if (r_n == AW'(1)) begin
                        r_mu_we <= 1'b1;
                        r_mu_wa <= r_n;
                        r_mu_wd <= mfs_pkg::MU_ONE;
                        r_n     <= r_n + 1'b1;
                    end else begin
                        r_ra    <= r_n;
                        r_state <= S_MU_WT;
                        r_p     <= '0;
                    end
                end
                S_MU_WT: r_state <= S_MU_DIV;
                S_MU_DIV: begin
                    if (r_p == '0) begin
                        r_p <= r_fac_rd;
                        if (r_fac_rd == r_n || r_fac_rd == '0) begin
                            r_mu_we <= 1'b1;
                            r_mu_wa <= r_n;
                            r_mu_wd <= mfs_pkg::MU_NEG;
                            r_n     <= r_n + 1'b1;
                            r_state <= S_MU_RD;
                        end else begin
                            r_div_go <= 1'b1;
                        end
                    end else if (w_div_done) begin
                        r_m      <= r_n;
                        r_n      <= w_quo;
                        r_div_go <= 1'b1;
                        r_state  <= S_MU_RDM;
                        r_ra     <= w_quo;
                    end
                end
                S_MU_RDM: begin
                    if (w_div_done) begin
                        r_mu_we <= 1'b1;
                        r_mu_wa <= r_m;
                        r_mu_wd <= (w_rem == '0) ? mfs_pkg::MU_ZERO : 2'(-r_mu_rd);
                        r_n     <= r_m + 1'b1;
                        r_state <= S_MU_RD;
                    end
                end
                S_Q_RD: r_state <= S_Q_OUT;
                S_Q_OUT: begin
                    r_omu    <= mfs_pkg::MU_ZERO;
                    r_ofac   <= '0;
                    r_oprime <= 1'b0;
                    if (!r_built) begin
                        r_ostat <= mfs_pkg::ST_UNBUILT;
                    end else if (AW'(r_idx) > r_lim) begin
                        r_ostat <= mfs_pkg::ST_RANGE;
                    end else begin
                        r_ostat  <= mfs_pkg::ST_OK;
                        r_omu    <= r_mu_rd;
                        r_ofac   <= r_fac_rd[15:0];
                        r_oprime <= (r_idx >= 16'd2) && (r_fac_rd == AW'(r_idx));
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_RESP;
                end
                S_RESP: begin
                    if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_mobius_value    = r_omu;
    assign o_smallest_factor = r_ofac;
    assign o_prime_flag      = r_oprime;
    assign o_status          = r_ostat;

    a_valid_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_RESP) else $error("valid outside response");
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != mfs_pkg::ST_OK) |-> (o_smallest_factor == '0))
        else $error("fields set on error status");
    a_counters_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_inner == '0 && r_outer == '0))
        else $error("build counters not cleared");
endmodule

// ===== tb/sv/mfs_checker.sv =====
`timescale 1ns / 100ps
// checker for the mobius function sieve: watches the config port and both
// channels, predicts each result word and compares it; depends on mfs_pkg
module mfs_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    input  logic              o_stall,
    input  logic              i_operation,
    input  logic [15:0]       i_index,
    input  logic              o_valid,
    input  logic              i_stall,
    input  logic signed [1:0] o_mobius_value,
    input  logic [15:0]       o_smallest_factor,
    input  logic              o_prime_flag,
    input  logic [1:0]        o_status,
    output int                fail_count,
    output int                pending
);
    typedef struct packed {
        logic signed [1:0] mu;
        logic [15:0]       factor;
        logic              prime;
        logic [1:0]        status;
    } t_answer;

    t_answer       answers_due[$];
    logic [15:0]   factor_mem [0:65535];
    logic signed [1:0] mu_mem [0:65535];
    logic          built;
    logic [15:0]   limit;

    function automatic void sieve_tables(int unsigned lim);
        int unsigned n, p, m;
        for (n = 0; n <= lim; n++) factor_mem[n] = 16'(n);
        for (p = 2; p * p <= lim; p++) begin
            if (int'(factor_mem[p]) == p) begin
                for (m = p * p; m <= lim; m += p) begin
                    if (int'(factor_mem[m]) == m) factor_mem[m] = 16'(p);
                end
            end
        end
        mu_mem[0] = mfs_pkg::MU_ZERO;
        if (lim >= 1) mu_mem[1] = mfs_pkg::MU_ONE;
        for (n = 2; n <= lim; n++) begin
            p = int'(factor_mem[n]);
            if (p == n || p == 0) mu_mem[n] = mfs_pkg::MU_NEG;
            else if (((n / p) % p) == 0) mu_mem[n] = mfs_pkg::MU_ZERO;
            else mu_mem[n] = -mu_mem[n / p];
        end
    endfunction

    function automatic t_answer predict_answer(logic op, logic [15:0] idx);
        t_answer a;
        a = '0;
        a.status = mfs_pkg::ST_OK;
        if (op == mfs_pkg::OP_BUILD) begin
            sieve_tables(int'(limit));
            built = 1'b1;
        end else if (!built) begin
            a.status = mfs_pkg::ST_UNBUILT;
        end else if (idx > limit) begin
            a.status = mfs_pkg::ST_RANGE;
        end else begin
            a.mu     = mu_mem[idx];
            a.factor = factor_mem[idx];
            a.prime  = (idx >= 16'd2) && (factor_mem[idx] == idx);
        end
        return a;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            built = 1'b0;
            limit = 16'hFFFF;
            answers_due.delete();
        end else begin
            if (o_valid && !i_stall) begin
                if (answers_due.size() == 0) begin
                    report("unexpected word", int'(o_status), -1);
                end else begin
                    want = answers_due.pop_front();
                    if (o_mobius_value !== want.mu)
                        report("mobius_value", int'(o_mobius_value), int'(want.mu));
                    if (o_smallest_factor !== want.factor)
                        report("smallest_factor", int'(o_smallest_factor),
                               int'(want.factor));
                    if (o_prime_flag !== want.prime)
                        report("prime_flag", int'(o_prime_flag), int'(want.prime));
                    if (o_status !== want.status)
                        report("status", int'(o_status), int'(want.status));
                end
            end
            if (i_cfg_we) begin
                limit = i_cfg_data;
                built = 1'b0;
            end
            if (i_valid && !o_stall)
                answers_due.push_back(predict_answer(i_operation, i_index));
        end
        pending = answers_due.size();
    end
endmodule

// ===== tb/sv/tb_mobius_function_sieve_top.sv =====
`timescale 1ns / 100ps
// testbench top for the mobius function sieve: drives config, queries and
// builds with random gaps and stalls; depends on mfs_pkg, mfs_checker, the rtl
module tb_mobius_function_sieve_top;
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [15:0]       i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_operation = mfs_pkg::OP_QUERY;
    logic [15:0]       i_index = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic signed [1:0] o_mobius_value;
    logic [15:0]       o_smallest_factor;
    logic              o_prime_flag;
    logic [1:0]        o_status;
    int                fail_count;
    int                pending;
    logic              calm = 1'b0;
    int                stall_left = 0;
    int unsigned       cur_limit = 65535;
    logic [15:0]       idx_list [0:8] = '{16'd2, 16'd4, 16'd6, 16'd12, 16'd29,
                                          16'd30, 16'd31, 16'd0, 16'd1};

    mobius_function_sieve_top uut (.*);

    mfs_checker u_checker (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #400ms;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && !i_stall) begin
            n = calm ? 0 : $urandom_range(0, 15);
            stall_left <= n;
            i_stall <= (n != 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= (stall_left > 1);
        end
    end

    task automatic send_word(logic op, logic [15:0] idx);
        int gap;
        logic stalled;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_index <= idx;
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
    endtask

    task automatic set_limit(logic [15:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_limit = 32'(value);
    endtask

    initial begin
        int k, j, nq;
        logic [15:0] idx;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unbuilt at reset limit
        send_word(mfs_pkg::OP_QUERY, 16'd0);
        send_word(mfs_pkg::OP_QUERY, 16'hFFFF);
        set_limit(16'd0);
        send_word(mfs_pkg::OP_QUERY, 16'd0);
        send_word(mfs_pkg::OP_BUILD, 16'hFFFF);
        send_word(mfs_pkg::OP_QUERY, 16'd0);
        send_word(mfs_pkg::OP_QUERY, 16'd1);
        send_word(mfs_pkg::OP_QUERY, 16'hFFFF);
        set_limit(16'd1);
        send_word(mfs_pkg::OP_BUILD, 16'd0);
        send_word(mfs_pkg::OP_QUERY, 16'd1);
        send_word(mfs_pkg::OP_QUERY, 16'd2);
        set_limit(16'd30);
        send_word(mfs_pkg::OP_QUERY, 16'd5);
        send_word(mfs_pkg::OP_BUILD, 16'h5555);
        foreach (idx_list[i]) send_word(mfs_pkg::OP_QUERY, idx_list[i]);

        for (k = 0; k < 10; k++) begin
            calm = ($urandom_range(0, 3) == 0);
            set_limit((k % 4 == 0) ? 16'($urandom_range(1, 3000))
                                   : 16'($urandom_range(2, 300)));
            send_word(mfs_pkg::OP_QUERY, 16'($urandom));
            send_word(mfs_pkg::OP_BUILD, 16'($urandom));
            nq = $urandom_range(120, 180);
            for (j = 0; j < nq; j++) begin
                if ($urandom_range(0, 59) == 0) begin
                    send_word(mfs_pkg::OP_BUILD, 16'($urandom));
                end else if ($urandom_range(0, 9) == 0) begin
                    send_word(mfs_pkg::OP_QUERY, 16'($urandom));
                end else begin
                    idx = 16'($urandom_range(0, cur_limit));
                    send_word(mfs_pkg::OP_QUERY, idx);
                end
                if ($urandom_range(0, 31) == 0) calm = !calm;
            end
        end

        calm = 1'b0;
        set_limit(16'hFFFF);
        for (j = 0; j < 20; j++) send_word(mfs_pkg::OP_QUERY, 16'($urandom));
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/mfs_pkg.sv
rtl/mfs_div.sv
rtl/mobius_function_sieve_top.sv
tb/sv/mfs_checker.sv
tb/sv/tb_mobius_function_sieve_top.sv
